/* sv/sep_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIEVE eviction policy package
// Shared request and response types, codes and sizes.
// ----------------------------------------------------------------------------
package sep_pkg;

  localparam int SEP_ENTRIES = 64;
  localparam int SEP_KEY_W   = 64;
  localparam int SEP_SIZE_W  = 32;
  localparam int SEP_CFG_AW  = 3;
  localparam int SEP_CFG_DW  = 32;

  typedef enum logic [1:0] {
    FUNC_HIT    = 2'd0,
    FUNC_MISS   = 2'd1,
    FUNC_EVICT  = 2'd2,
    FUNC_REMOVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_TOO_LARGE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4,
    STAT_DUPLICATE = 3'd5
  } status_t;

  localparam logic [SEP_CFG_AW-1:0] REG_CAPACITY = 3'd0;

  typedef struct packed {
    logic [1:0]            func;
    logic [SEP_KEY_W-1:0]  obj_key;
    logic [SEP_SIZE_W-1:0] byte_len;
  } in_req_t;

  typedef struct packed {
    logic [SEP_KEY_W-1:0] victim_key;
    logic                 victim_valid;
    logic [2:0]           status;
  } out_rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_INS,
    S_LINK,
    S_WALK,
    S_STEP,
    S_UNLINK,
    S_DONE
  } state_t;

endpackage

/* sv/sieve_eviction_policy.sv */
`timescale 1ns / 1ps
// Sequence: a hit, remove or miss scans the key memory one entry per cycle; a match ends
// the scan early. A remove then unlinks the entry in S_UNLINK; a miss insert writes the entry
// in S_INS and the old newest entry's newer link in S_LINK (S_INS only into an empty table).
// An evict walks the hand, clearing each marked entry it passes; S_STEP follows a newer link
// through the link memory, or the hand wraps to the oldest. One request is taken at a time.
// Reset clears the flags, list heads, hand and count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// SIEVE eviction policy
// Keys and list links live in synchronous memories; a sequencer searches,
// inserts, walks the hand and unlinks entries one memory access per cycle.
// ----------------------------------------------------------------------------
module sieve_eviction_policy
  import sep_pkg::*;
#(
  parameter int ENTRIES = SEP_ENTRIES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_rsp_t              out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [SEP_CFG_AW-1:0] paddr,
  input  logic [SEP_CFG_DW-1:0] pwdata,
  output logic [SEP_CFG_DW-1:0] prdata,
  output logic                  pready
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  logic [SEP_SIZE_W-1:0] capacity;

  sep_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  // Control and list state.
  state_t         state_r, state_nxt;
  in_req_t        req_r, req_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AW-1:0]  at_r, at_nxt;
  logic           rd_r, rd_nxt;
  logic [AW-1:0]  tgt_r, tgt_nxt;
  logic [AW-1:0]  ins_r, ins_nxt;
  logic [AW-1:0]  newest_r, newest_nxt;
  logic [AW-1:0]  oldest_r, oldest_nxt;
  logic [AW-1:0]  hand_r, hand_nxt;
  logic           live_r, live_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [ENTRIES-1:0] used_r, used_nxt;
  logic [ENTRIES-1:0] vis_r, vis_nxt;
  out_rsp_t       res_r, res_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_rsp_t       out_data_r, out_data_nxt;

  // Memory ports.
  logic                 key_we;
  logic [AW-1:0]        key_waddr, key_raddr;
  logic [SEP_KEY_W-1:0] key_wdata, key_rd;
  logic                 nwr_we, old_we;
  logic [AW-1:0]        nwr_waddr, nwr_wdata, old_waddr, old_wdata;
  logic [AW-1:0]        link_raddr, nwr_rd, old_rd;

  sep_ram #(.WIDTH(SEP_KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
    .raddr(key_raddr), .rdata(key_rd)
  );

  sep_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_newer_ram (
    .clk(clk), .we(nwr_we), .waddr(nwr_waddr), .wdata(nwr_wdata),
    .raddr(link_raddr), .rdata(nwr_rd)
  );

  sep_ram #(.WIDTH(AW), .DEPTH(ENTRIES)) u_older_ram (
    .clk(clk), .we(old_we), .waddr(old_waddr), .wdata(old_wdata),
    .raddr(link_raddr), .rdata(old_rd)
  );

  // Search compare: read data of the slot addressed in the previous cycle.
  logic srch_hit, srch_end;
  assign srch_hit = rd_r && used_r[at_r] && (key_rd == req_r.obj_key);
  assign srch_end = rd_r && (at_r == LAST);

  // Lowest-numbered free slot.
  logic          free_any;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_any = 1'b1;
        free_idx = AW'(i);
      end
    end
  end

  logic in_acc, out_free;
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Memory read addresses: the search walks the key memory, everything else
  // reads at the hand. A remove reads links at the slot the search found.
  assign key_raddr  = (state_r == S_SRCH) ? idx_r : hand_r;
  assign link_raddr = (state_r == S_SRCH) ? at_r  : hand_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.func)
            FUNC_MISS:  state_nxt = (in_data.byte_len > capacity) ? S_DONE : S_SRCH;
            FUNC_EVICT: state_nxt = (count_r == '0) ? S_DONE : S_WALK;
            default:    state_nxt = S_SRCH;
          endcase
        end
      end
      S_SRCH: begin
        priority if (srch_hit) begin
          state_nxt = (req_r.func == FUNC_REMOVE) ? S_UNLINK : S_DONE;
        end else if (srch_end) begin
          state_nxt = (req_r.func == FUNC_MISS && free_any) ? S_INS : S_DONE;
        end
      end
      S_INS:    state_nxt = (count_r == '0) ? S_DONE : S_LINK;
      S_LINK:   state_nxt = S_DONE;
      S_WALK: begin
        if (!vis_r[hand_r]) begin
          state_nxt = S_UNLINK;
        end else if (hand_r != newest_r) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP:   state_nxt = S_WALK;
      S_UNLINK: state_nxt = S_DONE;
      S_DONE:   state_nxt = out_free ? S_IDLE : S_DONE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory write controls.
  always_comb begin
    req_nxt      = req_r;
    idx_nxt      = idx_r;
    at_nxt       = at_r;
    rd_nxt       = rd_r;
    tgt_nxt      = tgt_r;
    ins_nxt      = ins_r;
    newest_nxt   = newest_r;
    oldest_nxt   = oldest_r;
    hand_nxt     = hand_r;
    live_nxt     = live_r;
    count_nxt    = count_r;
    used_nxt     = used_r;
    vis_nxt      = vis_r;
    res_nxt      = res_r;
    key_we       = 1'b0;
    key_waddr    = ins_r;
    key_wdata    = req_r.obj_key;
    nwr_we       = 1'b0;
    nwr_waddr    = ins_r;
    nwr_wdata    = ins_r;
    old_we       = 1'b0;
    old_waddr    = ins_r;
    old_wdata    = (count_r == '0) ? ins_r : newest_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_nxt = in_data;
          idx_nxt = '0;
          rd_nxt  = 1'b0;
          res_nxt = '0;
          if (in_data.func == FUNC_MISS && in_data.byte_len > capacity) begin
            res_nxt.status = STAT_TOO_LARGE;
          end
          if (in_data.func == FUNC_EVICT) begin
            if (count_r == '0) begin
              res_nxt.status = STAT_EMPTY;
            end else if (!live_r) begin
              hand_nxt = oldest_r;
              live_nxt = 1'b1;
            end
          end
        end
      end
      S_SRCH: begin
        rd_nxt  = 1'b1;
        at_nxt  = idx_r;
        idx_nxt = idx_r + AW'(1);
        priority if (srch_hit) begin
          unique case (req_r.func)
            FUNC_HIT:  vis_nxt[at_r] = 1'b1;
            FUNC_MISS: res_nxt.status = STAT_DUPLICATE;
            default:   tgt_nxt = at_r;
          endcase
        end else if (srch_end) begin
          if (req_r.func != FUNC_MISS) begin
            res_nxt.status = STAT_NOT_FOUND;
          end else if (!free_any) begin
            res_nxt.status = STAT_FULL;
          end else begin
            ins_nxt = free_idx;
          end
        end
      end
      S_INS: begin
        // New entry is its own newer link; its older link is the old newest.
        key_we = 1'b1;
        nwr_we = 1'b1;
        old_we = 1'b1;
        used_nxt[ins_r] = 1'b1;
        vis_nxt[ins_r]  = 1'b0;
        if (count_r == '0) begin
          oldest_nxt = ins_r;
          newest_nxt = ins_r;
          count_nxt  = count_r + CW'(1);
        end
      end
      S_LINK: begin
        nwr_we     = 1'b1;
        nwr_waddr  = newest_r;
        newest_nxt = ins_r;
        count_nxt  = count_r + CW'(1);
      end
      S_WALK: begin
        if (vis_r[hand_r]) begin
          vis_nxt[hand_r] = 1'b0;
          if (hand_r == newest_r) begin
            hand_nxt = oldest_r;
          end
        end else begin
          tgt_nxt = hand_r;
        end
      end
      S_STEP: begin
        hand_nxt = nwr_rd;
      end
      S_UNLINK: begin
        if (req_r.func == FUNC_EVICT) begin
          res_nxt.victim_key   = key_rd;
          res_nxt.victim_valid = 1'b1;
        end
        // Move the hand off the slot before it leaves the list.
        if (live_r && hand_r == tgt_r) begin
          if (count_r <= CW'(1)) begin
            live_nxt = 1'b0;
          end else if (hand_r == newest_r) begin
            hand_nxt = oldest_r;
          end else begin
            hand_nxt = nwr_rd;
          end
        end
        if (tgt_r == oldest_r) begin
          oldest_nxt = nwr_rd;
        end else begin
          nwr_we    = 1'b1;
          nwr_waddr = old_rd;
          nwr_wdata = nwr_rd;
        end
        if (tgt_r == newest_r) begin
          newest_nxt = old_rd;
        end else begin
          old_we    = 1'b1;
          old_waddr = nwr_rd;
          old_wdata = old_rd;
        end
        used_nxt[tgt_r] = 1'b0;
        vis_nxt[tgt_r]  = 1'b0;
        count_nxt       = count_r - CW'(1);
        if (count_r == CW'(1)) begin
          newest_nxt = '0;
          oldest_nxt = '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= '0;
      oldest_r    <= '0;
      hand_r      <= '0;
      live_r      <= 1'b0;
      count_r     <= '0;
      used_r      <= '0;
      vis_r       <= '0;
      rd_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      hand_r      <= hand_nxt;
      live_r      <= live_nxt;
      count_r     <= count_nxt;
      used_r      <= used_nxt;
      vis_r       <= vis_nxt;
      rd_r        <= rd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    at_r       <= at_nxt;
    tgt_r      <= tgt_nxt;
    ins_r      <= ins_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/sep_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/sep_cfg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIEVE configuration registers
// APB-style register file holding the capacity limit.
// ----------------------------------------------------------------------------
module sep_cfg
  import sep_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [SEP_CFG_AW-1:0] paddr,
  input  logic [SEP_CFG_DW-1:0] pwdata,
  output logic [SEP_CFG_DW-1:0] prdata,
  output logic                  pready,
  output logic [SEP_SIZE_W-1:0] capacity
);

  logic [SEP_SIZE_W-1:0] cap_r;
  logic                  sel_cap;

  // Only the word index is decoded; byte offsets are ignored.
  assign sel_cap = (paddr[SEP_CFG_AW-1:2] == REG_CAPACITY[SEP_CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= '1;
    end else if (psel && penable && pwrite && sel_cap) begin
      cap_r <= pwdata;
    end
  end

  assign pready   = 1'b1;
  assign prdata   = sel_cap ? cap_r : '0;
  assign capacity = cap_r;

endmodule

/* sv/sep_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SIEVE eviction policy checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sep_chk
  import sep_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input out_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("response changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in flight");

  a_victim_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.victim_valid |-> out_data.status == STAT_OK)
    else $error("victim reported with error status");

  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.victim_valid |-> out_data.victim_key == '0)
    else $error("nonzero key without victim");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= STAT_DUPLICATE)
    else $error("status code out of range");

endmodule

bind sieve_eviction_policy sep_chk u_sep_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
